// ===== hdl/rmst_pkg.sv =====
// Shared types, widths, codes and helpers for the range maximum segment tree.
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int OPCODE_W = 1;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 16;
  localparam int NODE_W   = 17;

  typedef logic        [OPCODE_W-1:0] opcode_t;
  typedef logic        [INDEX_W-1:0]  index_t;
  typedef logic        [VALUE_W-1:0]  value_t;
  typedef logic signed [NODE_W-1:0]   node_t;

  localparam opcode_t OP_QUERY = 1'b0;
  localparam opcode_t OP_RAISE = 1'b1;

  // entry never written / empty range
  localparam node_t EMPTY_NODE = '1;

  function automatic node_t node_max(node_t a, node_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/rmst_if.sv =====
// Channel interfaces: command input and query result output.
`timescale 1ns / 1ps

interface rmst_req_if;
  logic               valid;
  logic               ready;
  rmst_pkg::opcode_t  opcode;
  rmst_pkg::index_t   range_low;
  rmst_pkg::index_t   range_high;
  rmst_pkg::value_t   new_value;

  modport source (output valid, output opcode, output range_low, output range_high,
                  output new_value, input ready);
  modport sink   (input valid, input opcode, input range_low, input range_high,
                  input new_value, output ready);
endinterface

interface rmst_rsp_if;
  logic               valid;
  logic               ready;
  rmst_pkg::node_t    range_maximum;

  modport source (output valid, output range_maximum, input ready);
  modport sink   (input valid, input range_maximum, output ready);
endinterface

// ===== hdl/rmst_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module rmst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rmst_seq.sv =====
// Sequencer: clearing pass, update path walk and query node walk over the tree RAM.
`timescale 1ns / 1ps

module rmst_seq #(
  parameter int LEAVES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  rmst_req_if.sink                      req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rmst_pkg::node_t               res_data,
  output logic                          ram_we,
  output logic [$clog2(2*LEAVES)-1:0]   ram_waddr,
  output rmst_pkg::node_t               ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(2*LEAVES)-1:0]   ram_raddr,
  input  rmst_pkg::node_t               ram_rdata
);

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int WW    = $clog2(NODES + 1);
  localparam int IW    = (WW > rmst_pkg::INDEX_W) ? WW : rmst_pkg::INDEX_W;

  localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
  localparam logic [IW-1:0] LEAVES_I  = IW'(LEAVES);
  localparam logic [IW-1:0] TOP_LEAF  = IW'(LEAVES - 1);
  localparam logic [WW-1:0] LEAVES_W  = WW'(LEAVES);
  localparam logic [WW-1:0] ONE_W     = WW'(1);
  localparam logic [AW-1:0] ONE_A     = AW'(1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ULEAF = 3'd2;
  localparam logic [2:0] S_UUP   = 3'd3;
  localparam logic [2:0] S_QWALK = 3'd4;
  localparam logic [2:0] S_QFIN  = 3'd5;

  logic [2:0]      state, state_next;
  logic [AW-1:0]   cnt, cnt_next;
  logic            rd_pend, rd_pend_next;
  logic [WW-1:0]   l, l_next;
  logic [WW-1:0]   r, r_next;
  rmst_pkg::node_t cur, cur_next;
  rmst_pkg::node_t best, best_next;
  rmst_pkg::node_t val, val_next;

  logic [IW-1:0]   lo_ext;
  logic [IW-1:0]   hi_ext;
  logic [IW-1:0]   hi_clamp;
  logic [WW-1:0]   l_inc;
  logic [WW-1:0]   r_dec;
  logic [WW-1:0]   parent;
  rmst_pkg::node_t merged;
  rmst_pkg::node_t acc;

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_QFIN);
  assign res_data  = best;

  always_comb begin
    lo_ext   = IW'(req.range_low);
    hi_ext   = IW'(req.range_high);
    hi_clamp = (hi_ext >= LEAVES_I) ? TOP_LEAF : hi_ext;
    l_inc    = l + ONE_W;
    r_dec    = r - ONE_W;
    parent   = l >> 1;
    merged   = rmst_pkg::node_max(cur, ram_rdata);
    acc      = rd_pend ? rmst_pkg::node_max(best, ram_rdata) : best;

    state_next   = state;
    cnt_next     = cnt;
    rd_pend_next = 1'b0;
    l_next       = l;
    r_next       = r;
    cur_next     = cur;
    best_next    = best;
    val_next     = val;
    ram_we       = 1'b0;
    ram_waddr    = l[AW-1:0];
    ram_wdata    = cur;
    ram_re       = 1'b0;
    ram_raddr    = l[AW-1:0];

    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = rmst_pkg::EMPTY_NODE;
        cnt_next  = cnt + ONE_A;
        if (cnt == LAST_NODE) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          if (req.opcode == rmst_pkg::OP_RAISE) begin
            // out-of-table update is dropped
            if (lo_ext < LEAVES_I) begin
              l_next     = lo_ext[WW-1:0] + LEAVES_W;
              val_next   = rmst_pkg::node_t'({1'b0, req.new_value});
              ram_re     = 1'b1;
              ram_raddr  = l_next[AW-1:0];
              state_next = S_ULEAF;
            end
          end else begin
            best_next = rmst_pkg::EMPTY_NODE;
            if (lo_ext > hi_clamp) begin
              l_next = '0;
              r_next = '0;
            end else begin
              l_next = lo_ext[WW-1:0] + LEAVES_W;
              r_next = hi_clamp[WW-1:0] + LEAVES_W + ONE_W;
            end
            state_next = S_QWALK;
          end
        end
      end
      S_ULEAF: begin
        // leaf read back: raise it, fetch its sibling
        cur_next  = rmst_pkg::node_max(ram_rdata, val);
        ram_we    = 1'b1;
        ram_wdata = cur_next;
        ram_re    = 1'b1;
        ram_raddr = l[AW-1:0] ^ ONE_A;
        state_next = S_UUP;
      end
      S_UUP: begin
        // sibling arrives: write parent; siblings are off the path, so reads run ahead
        cur_next  = merged;
        ram_we    = 1'b1;
        ram_waddr = parent[AW-1:0];
        ram_wdata = merged;
        l_next    = parent;
        if (parent == ONE_W) begin
          state_next = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent[AW-1:0] ^ ONE_A;
        end
      end
      S_QWALK: begin
        best_next = acc;
        if (l < r) begin
          case ({l[0], r[0]})
            2'b11: begin
              ram_re       = 1'b1;
              rd_pend_next = 1'b1;
              l_next       = l_inc;
            end
            2'b10: begin
              ram_re       = 1'b1;
              rd_pend_next = 1'b1;
              l_next       = l_inc >> 1;
              r_next       = r >> 1;
            end
            2'b01: begin
              ram_re       = 1'b1;
              ram_raddr    = r_dec[AW-1:0];
              rd_pend_next = 1'b1;
              l_next       = l >> 1;
              r_next       = r >> 1;
            end
            default: begin
              l_next = l >> 1;
              r_next = r >> 1;
            end
          endcase
        end else begin
          state_next = S_QFIN;
        end
      end
      S_QFIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= rd_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    l    <= l_next;
    r    <= r_next;
    cur  <= cur_next;
    best <= best_next;
    val  <= val_next;
  end

endmodule

// ===== hdl/range_max_segment_tree_top.sv =====
// Top level: range maximum segment tree with tree RAM, sequencer and result register.
//
//   channel | dir | transfer                  | payload
//   --------+-----+---------------------------+-------------------------------------------
//   req     | in  | req.valid && req.ready    | opcode, range_low, range_high, new_value
//   rsp     | out | rsp.valid && rsp.ready    | range_maximum (signed, -1 when empty)
//
// After rst the tree RAM is swept to -1, one node a cycle, with req.ready low.
// One item at a time; the single RAM read port sets the pace. An update reads its leaf,
// raises it and writes each parent up to the root; a query reads at most two nodes per level.
// A query result sits in the output register; the next item is taken while it waits,
// and a later query holds in its last step until the register frees.
`timescale 1ns / 1ps

module range_max_segment_tree_top #(
  parameter int LEAVES = 1024
) (
  input logic        clk,
  input logic        rst,
  rmst_req_if.sink   req,
  rmst_rsp_if.source rsp
);

  localparam int AW = $clog2(2 * LEAVES);

  logic            res_valid;
  logic            res_ready;
  rmst_pkg::node_t res_data;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  rmst_pkg::node_t ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  rmst_pkg::node_t ram_rdata;
  logic            out_valid;
  rmst_pkg::node_t out_data;

  rmst_seq #(
    .LEAVES (LEAVES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rmst_ram #(
    .WIDTH (rmst_pkg::NODE_W),
    .DEPTH (2 * LEAVES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready         = !out_valid || rsp.ready;
  assign rsp.valid         = out_valid;
  assign rsp.range_maximum = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule
